// ===== hw/rtl/urtb_pkg.sv =====
// Shared types and codes for the UART receive/transmit ring buffer block.
`default_nettype none
package urtb_pkg;

    typedef enum logic [1:0] {
        OP_TX_PUSH = 2'd0,
        OP_TX_POP  = 2'd1,
        OP_RX_PUSH = 2'd2,
        OP_RX_POP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_FRAME    = 2'd1,
        ERR_OVERRUN  = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FRAME    = 3'd1,
        ST_OVERRUN  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_NODATA   = 3'd4
    } t_rx_status;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_TX   = 2'd1,
        SRC_RX   = 2'd2
    } t_src;

    // Controller to datapath
    typedef struct packed {
        logic tx_push;
        logic tx_pop;
        logic rx_push;
        logic rx_pop;
        logic err_load;
        t_src out_sel;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic tx_full;
        logic tx_empty;
        logic rx_full;
        logic rx_empty;
        t_err latched_err;
    } t_status;

endpackage
`default_nettype wire

// ===== hw/rtl/uart_rx_tx_ring_buffers_core.sv =====
// Top level of the UART receive/transmit ring buffer block.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per transfer:
//   queue a transmit byte, hand the next transmit byte to the shifter, store a
//   received byte with its frame/overrun flags, or read a received byte.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   operation: out_byte with byte_valid, rx_status and tx_rejected.
//   Each buffer holds DEPTH-1 bytes; one slot always stays empty.
// Result: the result is valid in the cycle after the input transfer; popped
//   bytes come straight from the registered read port of the byte RAM.
// Throughput: one operation per cycle while the output side takes every
//   result; the single output register sets this figure.
// Stall: while a result waits, o_in_ready follows i_out_ready, so a new
//   operation is taken only in the cycle the held result leaves.
// Reset: i_rst_n low clears all four pointers and the error latch, so both
//   buffers come up empty; byte RAM contents are not cleared.
`default_nettype none
module uart_rx_tx_ring_buffers_core #(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_frame_error,
    input  wire logic       i_overrun_error,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_out_byte,
    output logic            o_byte_valid,
    output logic      [2:0] o_rx_status,
    output logic            o_tx_rejected
);
    import urtb_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    urtb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (w_status),
        .o_cmd         (w_cmd),
        .o_byte_valid  (o_byte_valid),
        .o_rx_status   (o_rx_status),
        .o_tx_rejected (o_tx_rejected)
    );

    urtb_dpath #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_in_byte       (i_in_byte),
        .i_frame_error   (i_frame_error),
        .i_overrun_error (i_overrun_error),
        .o_status        (w_status),
        .o_out_byte      (o_out_byte)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/urtb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module urtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/urtb_dpath.sv =====
// Datapath: ring pointers, byte stores, receive error latch and output byte select.
`default_nettype none
module urtb_dpath #(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire urtb_pkg::t_cmd   i_cmd,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_frame_error,
    input  wire logic             i_overrun_error,
    output urtb_pkg::t_status     o_status,
    output logic      [7:0]       o_out_byte
);
    import urtb_pkg::*;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    logic [RX_AW-1:0] r_rx_wptr, r_rx_rptr, n_rx_wptr_adv, n_rx_rptr_adv;
    logic [TX_AW-1:0] r_tx_wptr, r_tx_rptr, n_tx_wptr_adv, n_tx_rptr_adv;
    t_err             r_err, n_err;
    logic [7:0]       w_rx_rdata, w_tx_rdata;

    // Wrap from the last slot back to zero
    always_comb begin
        n_rx_wptr_adv = (r_rx_wptr == RX_LAST) ? '0 : r_rx_wptr + 1'b1;
        n_rx_rptr_adv = (r_rx_rptr == RX_LAST) ? '0 : r_rx_rptr + 1'b1;
        n_tx_wptr_adv = (r_tx_wptr == TX_LAST) ? '0 : r_tx_wptr + 1'b1;
        n_tx_rptr_adv = (r_tx_rptr == TX_LAST) ? '0 : r_tx_rptr + 1'b1;
    end

    always_comb begin
        if (o_status.rx_full) begin
            n_err = ERR_OVERFLOW;
        end else if (i_overrun_error) begin
            n_err = ERR_OVERRUN;
        end else if (i_frame_error) begin
            n_err = ERR_FRAME;
        end else begin
            n_err = ERR_OK;
        end
    end

    assign o_status.tx_full     = (n_tx_wptr_adv == r_tx_rptr);
    assign o_status.tx_empty    = (r_tx_wptr == r_tx_rptr);
    assign o_status.rx_full     = (n_rx_wptr_adv == r_rx_rptr);
    assign o_status.rx_empty    = (r_rx_wptr == r_rx_rptr);
    assign o_status.latched_err = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wptr <= '0;
            r_rx_rptr <= '0;
            r_tx_wptr <= '0;
            r_tx_rptr <= '0;
            r_err     <= ERR_OK;
        end else begin
            if (i_cmd.rx_push)  r_rx_wptr <= n_rx_wptr_adv;
            if (i_cmd.rx_pop)   r_rx_rptr <= n_rx_rptr_adv;
            if (i_cmd.tx_push)  r_tx_wptr <= n_tx_wptr_adv;
            if (i_cmd.tx_pop)   r_tx_rptr <= n_tx_rptr_adv;
            if (i_cmd.err_load) r_err     <= n_err;
        end
    end

    urtb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.rx_push),
        .i_wr_addr (n_rx_wptr_adv),
        .i_wr_data (i_in_byte),
        .i_rd_en   (i_cmd.rx_pop),
        .i_rd_addr (n_rx_rptr_adv),
        .o_rd_data (w_rx_rdata)
    );

    urtb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.tx_push),
        .i_wr_addr (n_tx_wptr_adv),
        .i_wr_data (i_in_byte),
        .i_rd_en   (i_cmd.tx_pop),
        .i_rd_addr (n_tx_rptr_adv),
        .o_rd_data (w_tx_rdata)
    );

    // Read data holds until the next pop, so it can drive the result directly
    always_comb begin
        case (i_cmd.out_sel)
            SRC_TX:  o_out_byte = w_tx_rdata;
            SRC_RX:  o_out_byte = w_rx_rdata;
            default: o_out_byte = 8'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/urtb_ctrl.sv =====
// Controller: handshake state machine, operation decode and result flags.
`default_nettype none
module urtb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_operation,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire urtb_pkg::t_status i_status,
    output urtb_pkg::t_cmd         o_cmd,
    output logic                   o_byte_valid,
    output logic [2:0]             o_rx_status,
    output logic                   o_tx_rejected
);
    import urtb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    t_state     r_state, n_state;
    logic       r_byte_valid, n_byte_valid;
    t_rx_status r_rx_status, n_rx_status;
    logic       r_tx_rejected, n_tx_rejected;
    t_src       r_sel, n_sel;
    logic       w_accept;
    t_op        w_op;

    assign w_op       = t_op'(i_operation);
    // A held result that is leaving this cycle frees the output register
    assign o_in_ready = (r_state == S_IDLE) || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state          = r_state;
        n_byte_valid     = r_byte_valid;
        n_rx_status      = r_rx_status;
        n_tx_rejected    = r_tx_rejected;
        n_sel            = r_sel;
        o_cmd.tx_push    = 1'b0;
        o_cmd.tx_pop     = 1'b0;
        o_cmd.rx_push    = 1'b0;
        o_cmd.rx_pop     = 1'b0;
        o_cmd.err_load   = 1'b0;
        o_cmd.out_sel    = r_sel;
        if (w_accept) begin
            n_state       = S_HOLD;
            n_byte_valid  = 1'b0;
            n_rx_status   = ST_OK;
            n_tx_rejected = 1'b0;
            n_sel         = SRC_NONE;
            case (w_op)
                OP_TX_PUSH: begin
                    o_cmd.tx_push = !i_status.tx_full;
                    n_tx_rejected = i_status.tx_full;
                end
                OP_TX_POP: begin
                    if (!i_status.tx_empty) begin
                        o_cmd.tx_pop = 1'b1;
                        n_byte_valid = 1'b1;
                        n_sel        = SRC_TX;
                    end
                end
                OP_RX_PUSH: begin
                    o_cmd.rx_push  = !i_status.rx_full;
                    o_cmd.err_load = 1'b1;
                end
                OP_RX_POP: begin
                    if (i_status.rx_empty) begin
                        n_rx_status = ST_NODATA;
                    end else begin
                        o_cmd.rx_pop = 1'b1;
                        n_byte_valid = 1'b1;
                        n_sel        = SRC_RX;
                        n_rx_status  = t_rx_status'({1'b0, i_status.latched_err});
                    end
                end
                default: begin
                    n_sel = SRC_NONE;
                end
            endcase
        end else if ((r_state == S_HOLD) && i_out_ready) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_byte_valid  <= 1'b0;
            r_rx_status   <= ST_OK;
            r_tx_rejected <= 1'b0;
            r_sel         <= SRC_NONE;
        end else begin
            r_state       <= n_state;
            r_byte_valid  <= n_byte_valid;
            r_rx_status   <= n_rx_status;
            r_tx_rejected <= n_tx_rejected;
            r_sel         <= n_sel;
        end
    end

    assign o_out_valid   = (r_state == S_HOLD);
    assign o_byte_valid  = r_byte_valid;
    assign o_rx_status   = r_rx_status;
    assign o_tx_rejected = r_tx_rejected;

endmodule
`default_nettype wire

// ===== hw/rtl/urtb_chk.sv =====
// Port-level assertion checker for the ring buffer block, bound to the top level.
`default_nettype none
module urtb_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_byte_valid,
    input wire logic [2:0] o_rx_status,
    input wire logic       o_tx_rejected
);
    import urtb_pkg::*;

    // Held result stays put while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_byte_valid) && $stable(o_rx_status) && $stable(o_tx_rejected))
        else $error("result changed while stalled");

    // Every transfer in produces a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("no result one cycle after input transfer");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_out_byte == 8'd0)
        else $error("nonzero byte without byte_valid");

    // Rejection, no-data and popped byte exclude each other
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_tx_rejected || o_rx_status == ST_NODATA)
            |-> !o_byte_valid && !(o_tx_rejected && o_rx_status != ST_OK))
        else $error("conflicting result flags");

endmodule

bind uart_rx_tx_ring_buffers_core urtb_chk u_urtb_chk (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the UART receive/transmit ring buffer core.
`timescale 1ns / 1ps
module tb;
    import urtb_pkg::*;

    localparam int RING_DEPTH  = 16;
    localparam int NUM_ITEMS   = 1050;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_PRINTS  = 40;

    typedef enum int {
        FILL_TX,
        DRAIN_TX,
        FILL_RX,
        DRAIN_RX,
        MIXED
    } burst_mode_t;

    typedef struct {
        logic [7:0] data;
        logic       data_ok;
        t_rx_status status;
        logic       rejected;
    } ring_result_t;

    // Tracks both rings and the error latch; holds the results still owed by the core.
    class ring_scoreboard;
        logic [7:0]   tx_mem [RING_DEPTH];
        logic [7:0]   rx_mem [RING_DEPTH];
        int           tx_wr = 0;
        int           tx_rd = 0;
        int           rx_wr = 0;
        int           rx_rd = 0;
        t_err         last_err = ERR_OK;
        ring_result_t owed_results[$];
        int           errors = 0;

        function void note_input(t_op op, logic [7:0] data, logic fe, logic oe);
            ring_result_t res;
            int nxt;
            res.data = 8'h00;
            res.data_ok = 1'b0;
            res.status = ST_OK;
            res.rejected = 1'b0;
            case (op)
                OP_TX_PUSH: begin
                    nxt = (tx_wr + 1) % RING_DEPTH;
                    if (nxt == tx_rd) begin
                        res.rejected = 1'b1;
                    end else begin
                        tx_mem[nxt] = data;
                        tx_wr = nxt;
                    end
                end
                OP_TX_POP: begin
                    if (tx_wr != tx_rd) begin
                        tx_rd = (tx_rd + 1) % RING_DEPTH;
                        res.data = tx_mem[tx_rd];
                        res.data_ok = 1'b1;
                    end
                end
                OP_RX_PUSH: begin
                    // overflow beats overrun, overrun beats frame
                    last_err = ERR_OK;
                    if (fe)
                        last_err = ERR_FRAME;
                    if (oe)
                        last_err = ERR_OVERRUN;
                    nxt = (rx_wr + 1) % RING_DEPTH;
                    if (nxt == rx_rd) begin
                        last_err = ERR_OVERFLOW;
                    end else begin
                        rx_mem[nxt] = data;
                        rx_wr = nxt;
                    end
                end
                default: begin
                    if (rx_wr == rx_rd) begin
                        res.status = ST_NODATA;
                    end else begin
                        rx_rd = (rx_rd + 1) % RING_DEPTH;
                        res.data = rx_mem[rx_rd];
                        res.data_ok = 1'b1;
                        res.status = t_rx_status'({1'b0, last_err});
                    end
                end
            endcase
            owed_results.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [7:0] data, logic data_ok, logic [2:0] status,
                          logic rejected);
            ring_result_t want;
            if (owed_results.size() == 0) begin
                report("result transfer with nothing outstanding");
                return;
            end
            want = owed_results.pop_front();
            if (data !== want.data)
                report($sformatf("out_byte %02h, want %02h", data, want.data));
            if (data_ok !== want.data_ok)
                report($sformatf("byte_valid %b, want %b", data_ok, want.data_ok));
            if (status !== want.status)
                report($sformatf("rx_status %0d, want %0d", status, want.status));
            if (rejected !== want.rejected)
                report($sformatf("tx_rejected %b, want %b", rejected, want.rejected));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] op_in = OP_TX_PUSH;
    logic [7:0] in_data = 8'h00;
    logic       frame_err = 1'b0;
    logic       overrun_err = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_data;
    logic       data_valid;
    logic [2:0] rx_status;
    logic       tx_rejected;

    bit             allow_idle = 1'b1;
    int             sent_count = 0;
    ring_scoreboard board;

    uart_rx_tx_ring_buffers_core #(
        .RX_DEPTH(RING_DEPTH),
        .TX_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operation    (op_in),
        .i_in_byte      (in_data),
        .i_frame_error  (frame_err),
        .i_overrun_error(overrun_err),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_out_byte     (out_data),
        .o_byte_valid   (data_valid),
        .o_rx_status    (rx_status),
        .o_tx_rejected  (tx_rejected)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one operation, with an occasional idle burst ahead of it; return on transfer.
    task automatic send_op(t_op op, logic [7:0] data, logic fe, logic oe);
        int gap;
        if (allow_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op_in       <= op;
        in_data     <= data;
        frame_err   <= fe;
        overrun_err <= oe;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_input(op, data, fe, oe);
        sent_count++;
    endtask

    // Bursts biased toward filling or draining one ring, or mixed, so both rings hit full and empty.
    task automatic send_random(int count);
        burst_mode_t mode;
        t_op         op;
        int          len;
        int          r;
        int          k;
        k = 0;
        while (k < count) begin
            mode = burst_mode_t'($urandom_range(FILL_TX, MIXED));
            len = $urandom_range(4, 24);
            while (len > 0 && k < count) begin
                r = $urandom_range(0, 9);
                case (mode)
                    FILL_TX:  op = (r < 8) ? OP_TX_PUSH : OP_TX_POP;
                    DRAIN_TX: op = (r < 8) ? OP_TX_POP : OP_TX_PUSH;
                    FILL_RX:  op = (r < 8) ? OP_RX_PUSH : OP_RX_POP;
                    DRAIN_RX: op = (r < 8) ? OP_RX_POP : OP_RX_PUSH;
                    default:  op = t_op'($urandom_range(0, 3));
                endcase
                send_op(op, 8'($urandom), 1'($urandom), 1'($urandom));
                len--;
                k++;
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off so the core backs up.
    initial begin
        int  stall;
        int  taken;
        bit  held;
        stall = 0;
        taken = 0;
        held = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                board.check_result(out_data, data_valid, rx_status, tx_rejected);
                taken++;
                if (taken == HOLD_AFTER && !held) begin
                    held = 1'b1;
                    stall = HOLD_CYCLES;
                end
            end
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    initial begin
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty rings on both sides
        send_op(OP_RX_POP, 8'hFF, 1'b1, 1'b1);
        send_op(OP_TX_POP, 8'h00, 1'b0, 1'b0);
        // transmit ring: extreme bytes, flags ignored
        send_op(OP_TX_PUSH, 8'h00, 1'b0, 1'b0);
        send_op(OP_TX_PUSH, 8'hFF, 1'b0, 1'b0);
        send_op(OP_TX_PUSH, 8'hA5, 1'b1, 1'b1);
        send_op(OP_TX_POP, 8'h5A, 1'b0, 1'b0);
        send_op(OP_TX_POP, 8'h00, 1'b0, 1'b0);
        send_op(OP_TX_POP, 8'h00, 1'b0, 1'b0);
        send_op(OP_TX_POP, 8'h00, 1'b0, 1'b0);
        // receive ring: each error flag, and overrun winning over frame
        send_op(OP_RX_PUSH, 8'hFF, 1'b0, 1'b0);
        send_op(OP_RX_PUSH, 8'h00, 1'b1, 1'b0);
        send_op(OP_RX_PUSH, 8'h5A, 1'b0, 1'b1);
        send_op(OP_RX_PUSH, 8'hC3, 1'b1, 1'b1);
        repeat (4) send_op(OP_RX_POP, 8'h00, 1'b0, 1'b0);
        // latch stays put across an empty read
        send_op(OP_RX_POP, 8'h00, 1'b0, 1'b0);
        // a clean byte overwrites the latch
        send_op(OP_RX_PUSH, 8'h81, 1'b1, 1'b0);
        send_op(OP_RX_PUSH, 8'h7E, 1'b0, 1'b0);
        send_op(OP_RX_POP, 8'h00, 1'b0, 1'b0);
        send_op(OP_RX_POP, 8'h00, 1'b0, 1'b0);
        send_op(OP_RX_POP, 8'h00, 1'b0, 1'b0);

        send_random(NUM_ITEMS - sent_count - CALM_ITEMS);
        allow_idle = 1'b0;
        send_random(CALM_ITEMS);
        in_valid <= 1'b0;

        while (board.owed_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
